@@ rtl/core/rtbc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtbc_pkg
// Shared constants for the two-body regularization datapath.
// ----------------------------------------------------------------------------
package rtbc_pkg;

	// particles handled side by side, one lane each
	localparam int NUM_LANES  = 2;
	// fields per particle on the input side: x, y, px, py
	localparam int IN_FIELDS  = 4;
	// fields per particle on the output side: u1, u2, p1, p2
	localparam int OUT_FIELDS = 4;

endpackage

@@ rtl/core/rtbc_mul.sv @@
// ----------------------------------------------------------------------------
// rtbc_mul
// Two-stage unsigned multiplier bank, split into half-width partial products.
// ----------------------------------------------------------------------------
module rtbc_mul #(
	parameter int N      = 2,
	parameter int W      = 32,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [N*W-1:0]      a,
	input  logic [N*W-1:0]      b,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output logic [N*2*W-1:0]    p,
	output logic [SIDE_W-1:0]   out_side
);

	localparam int H  = (W + 1) / 2;
	localparam int H2 = 2 * H;

	logic              valid_s1, valid_s2;
	logic [SIDE_W-1:0] side_s1, side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			side_s2 <= side_s1;
		end
	end

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_prod
			logic [H2-1:0]   aw, bw;
			logic [H2-1:0]   ll_s1, lh_s1, hl_s1, hh_s1;
			logic [H2:0]     mid;
			logic [2*H2-1:0] full;
			logic [2*W-1:0]  p_s2;

			assign aw = H2'(a[k*W +: W]);
			assign bw = H2'(b[k*W +: W]);

			always_ff @(posedge clk) begin
				if (en) begin
					ll_s1 <= aw[H-1:0] * bw[H-1:0];
					lh_s1 <= aw[H-1:0] * bw[H2-1:H];
					hl_s1 <= aw[H2-1:H] * bw[H-1:0];
					hh_s1 <= aw[H2-1:H] * bw[H2-1:H];
				end
			end

			assign mid  = {1'b0, lh_s1} + {1'b0, hl_s1};
			assign full = {hh_s1, ll_s1} + ({{(H2-1){1'b0}}, mid} << H);

			always_ff @(posedge clk) begin
				if (en) begin
					p_s2 <= full[2*W-1:0];
				end
			end

			assign p[k*2*W +: 2*W] = p_s2;
		end
	endgenerate

	assign out_valid = valid_s2;
	assign out_side  = side_s2;

endmodule

@@ rtl/core/rtbc_sqrt.sv @@
// ----------------------------------------------------------------------------
// rtbc_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rtbc_sqrt #(
	parameter int IN_W   = 64,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [IN_W-1:0]     radicand,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output logic [IN_W/2-1:0]   root,
	output logic [SIDE_W-1:0]   out_side
);

	localparam int R  = IN_W / 2;
	localparam int RW = R + 1;

	logic              vld_q  [1:R];
	logic [RW-1:0]     rem_q  [1:R];
	logic [R-1:0]      root_q [1:R];
	logic [IN_W-1:0]   rad_q  [1:R];
	logic [SIDE_W-1:0] side_q [1:R];

	genvar g;
	generate
		for (g = 0; g < R; g++) begin : g_stage
			logic              vld_c;
			logic [RW-1:0]     rem_c;
			logic [R-1:0]      root_c;
			logic [IN_W-1:0]   rad_c;
			logic [SIDE_W-1:0] side_c;
			logic [RW+1:0]     rem_n, trial, diff;
			logic              ge;

			if (g == 0) begin : g_src
				assign vld_c  = in_valid;
				assign rem_c  = '0;
				assign root_c = '0;
				assign rad_c  = radicand;
				assign side_c = in_side;
			end else begin : g_src
				assign vld_c  = vld_q[g];
				assign rem_c  = rem_q[g];
				assign root_c = root_q[g];
				assign rad_c  = rad_q[g];
				assign side_c = side_q[g];
			end

			assign rem_n = {rem_c, rad_c[IN_W-1 -: 2]};
			assign trial = {1'b0, root_c, 2'b01};
			assign diff  = rem_n - trial;
			assign ge    = rem_n >= trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[g+1] <= 1'b0;
				end else if (en) begin
					vld_q[g+1] <= vld_c;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[g+1]  <= ge ? diff[RW-1:0] : rem_n[RW-1:0];
					root_q[g+1] <= {root_c[R-2:0], ge};
					rad_q[g+1]  <= {rad_c[IN_W-3:0], 2'b00};
					side_q[g+1] <= side_c;
				end
			end
		end
	endgenerate

	assign out_valid = vld_q[R];
	assign root      = root_q[R];
	assign out_side  = side_q[R];

endmodule

@@ rtl/core/rtbc_div.sv @@
// ----------------------------------------------------------------------------
// rtbc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rtbc_div #(
	parameter int ND     = 47,
	parameter int DW     = 24,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [ND-1:0]       numerator,
	input  logic [DW-1:0]       divisor,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output logic [ND-1:0]       quotient,
	output logic [SIDE_W-1:0]   out_side
);

	logic              vld_q  [1:ND];
	logic [DW-1:0]     rem_q  [1:ND];
	logic [ND-1:0]     num_q  [1:ND];
	logic [ND-1:0]     quo_q  [1:ND];
	logic [DW-1:0]     dv_q   [1:ND];
	logic [SIDE_W-1:0] side_q [1:ND];

	genvar g;
	generate
		for (g = 0; g < ND; g++) begin : g_stage
			logic              vld_c;
			logic [DW-1:0]     rem_c, dv_c;
			logic [ND-1:0]     num_c, quo_c;
			logic [SIDE_W-1:0] side_c;
			logic [DW:0]       rem_n, diff;
			logic              ge;

			if (g == 0) begin : g_src
				assign vld_c  = in_valid;
				assign rem_c  = '0;
				assign num_c  = numerator;
				assign quo_c  = '0;
				assign dv_c   = divisor;
				assign side_c = in_side;
			end else begin : g_src
				assign vld_c  = vld_q[g];
				assign rem_c  = rem_q[g];
				assign num_c  = num_q[g];
				assign quo_c  = quo_q[g];
				assign dv_c   = dv_q[g];
				assign side_c = side_q[g];
			end

			assign rem_n = {rem_c, num_c[ND-1]};
			assign diff  = rem_n - {1'b0, dv_c};
			assign ge    = rem_n >= {1'b0, dv_c};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[g+1] <= 1'b0;
				end else if (en) begin
					vld_q[g+1] <= vld_c;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[g+1]  <= ge ? diff[DW-1:0] : rem_n[DW-1:0];
					num_q[g+1]  <= {num_c[ND-2:0], 1'b0};
					quo_q[g+1]  <= {quo_c[ND-2:0], ge};
					dv_q[g+1]   <= dv_c;
					side_q[g+1] <= side_c;
				end
			end
		end
	endgenerate

	assign out_valid = vld_q[ND];
	assign quotient  = quo_q[ND];
	assign out_side  = side_q[ND];

endmodule

@@ rtl/core/rtbc_lane.sv @@
// ----------------------------------------------------------------------------
// rtbc_lane
// One particle: radius, square-root component, quotient, momenta.
// ----------------------------------------------------------------------------
module rtbc_lane #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic [rtbc_pkg::IN_FIELDS*W-1:0] in_data,
	output logic                             out_valid,
	output logic [W-1:0]                     out_u1,
	output logic [W-1:0]                     out_u2,
	output logic [W-1:0]                     out_p1,
	output logic [W-1:0]                     out_p2,
	output logic                             out_org
);

	localparam int T_W = W + F;
	localparam int T_E = T_W + (T_W % 2);
	localparam int R2  = T_E / 2;
	localparam int ND  = W + F - 1;
	localparam int MW  = ND + 1;
	localparam int SW  = 2 * W + 2;
	localparam int S1  = 4 + 4 * W;
	localparam int S2  = 4 + 3 * W;
	localparam int S3  = 4 + 2 * W + R2;
	localparam int S4  = 5 + 2 * W;

	localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] MINV = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [SW-1:0] BIAS = {{(SW-F+1){1'b0}}, {(F-1){1'b1}}};

	function automatic logic [W-1:0] shsat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] adj;
		logic signed [SW-1:0] sh;
		begin
			adj = v + (v[SW-1] ? BIAS : '0);
			sh  = adj >>> (F - 1);
			if (sh > MAXV) begin
				shsat = MAXV[W-1:0];
			end else if (sh < MINV) begin
				shsat = MINV[W-1:0];
			end else begin
				shsat = sh[W-1:0];
			end
		end
	endfunction

	// input decode
	logic [W-1:0] x, y, px, py, xm, ym, pxm, pym;
	logic         xn, yn, pxn, pyn;

	assign x   = in_data[0*W +: W];
	assign y   = in_data[1*W +: W];
	assign px  = in_data[2*W +: W];
	assign py  = in_data[3*W +: W];
	assign xn  = x[W-1];
	assign yn  = y[W-1];
	assign pxn = px[W-1];
	assign pyn = py[W-1];
	assign xm  = xn ? (~x + 1'b1) : x;
	assign ym  = yn ? (~y + 1'b1) : y;
	assign pxm = pxn ? (~px + 1'b1) : px;
	assign pym = pyn ? (~py + 1'b1) : py;

	// squares
	logic            sq_valid;
	logic [4*W-1:0]  sq_p;
	logic [S1-1:0]   sq_side;

	rtbc_mul #(.N(2), .W(W), .SIDE_W(S1)) u_sq (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_valid),
		.a({ym, xm}), .b({ym, xm}),
		.in_side({xn, yn, pxn, pyn, xm, ym, pxm, pym}),
		.out_valid(sq_valid), .p(sq_p), .out_side(sq_side)
	);

	logic            valid_s2;
	logic [2*W-1:0]  rad_s2;
	logic [S1-1:0]   side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2  <= sq_p[2*W-1:0] + sq_p[4*W-1:2*W];
			side_s2 <= sq_side;
		end
	end

	// radius
	logic          r_valid;
	logic [W-1:0]  r;
	logic [S1-1:0] r_side;

	rtbc_sqrt #(.IN_W(2*W), .SIDE_W(S1)) u_radius (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s2), .radicand(rad_s2), .in_side(side_s2),
		.out_valid(r_valid), .root(r), .out_side(r_side)
	);

	logic           valid_s4;
	logic [T_E-1:0] t_s4;
	logic [S2-1:0]  side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= r_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4    <= T_E'({1'b0, r} + {1'b0, r_side[4*W-1:3*W]}) << (F - 1);
			side_s4 <= {r_side[4*W+3:4*W], r_side[3*W-1:0]};
		end
	end

	// square-root component
	logic          s_valid;
	logic [R2-1:0] s_root;
	logic [S2-1:0] s_side;

	rtbc_sqrt #(.IN_W(T_E), .SIDE_W(S2)) u_comp (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s4), .radicand(t_s4), .in_side(side_s4),
		.out_valid(s_valid), .root(s_root), .out_side(s_side)
	);

	// other component
	logic          q_valid;
	logic [ND-1:0] q;
	logic [S3-1:0] q_side;

	rtbc_div #(.ND(ND), .DW(R2), .SIDE_W(S3)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_valid),
		.numerator({s_side[3*W-1:2*W], {(F-1){1'b0}}}),
		.divisor(s_root),
		.in_side({s_side[3*W+3:3*W], s_side[2*W-1:0], s_root}),
		.out_valid(q_valid), .quotient(q), .out_side(q_side)
	);

	logic [R2-1:0] dv_s;
	logic [W-1:0]  d_pym, d_pxm, sbm, vm, vlim, vb, sb;
	logic          d_pyn, d_pxn, d_yn, d_xn, vn;

	assign dv_s  = q_side[R2-1:0];
	assign d_pym = q_side[R2 +: W];
	assign d_pxm = q_side[R2+W +: W];
	assign d_pyn = q_side[R2+2*W];
	assign d_pxn = q_side[R2+2*W+1];
	assign d_yn  = q_side[R2+2*W+2];
	assign d_xn  = q_side[R2+2*W+3];

	assign sbm  = (MW'(dv_s) > MW'(LIM_POS)) ? LIM_POS : W'(dv_s);
	assign vlim = d_yn ? LIM_NEG : LIM_POS;
	assign vm   = (MW'(q) > MW'(vlim)) ? vlim : q[W-1:0];
	assign vn   = d_yn && (vm != '0);
	assign vb   = d_yn ? (~vm + 1'b1) : vm;
	assign sb   = sbm;

	logic          valid_s7, org_s7, u1n_s7, u2n_s7, pxn_s7, pyn_s7;
	logic [W-1:0]  u1_s7, u2_s7, u1m_s7, u2m_s7, pxm_s7, pym_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			org_s7 <= (dv_s == '0);
			u1_s7  <= d_xn ? vb : sb;
			u2_s7  <= d_xn ? sb : vb;
			u1m_s7 <= d_xn ? vm : sbm;
			u2m_s7 <= d_xn ? sbm : vm;
			u1n_s7 <= d_xn ? vn : 1'b0;
			u2n_s7 <= d_xn ? 1'b0 : vn;
			pxm_s7 <= d_pxm;
			pym_s7 <= d_pym;
			pxn_s7 <= d_pxn;
			pyn_s7 <= d_pyn;
		end
	end

	// momentum products: u1*px, u2*py, u1*py, u2*px
	logic           m_valid;
	logic [8*W-1:0] m_p;
	logic [S4-1:0]  m_side;

	rtbc_mul #(.N(4), .W(W), .SIDE_W(S4)) u_mom (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s7),
		.a({u2m_s7, u1m_s7, u2m_s7, u1m_s7}),
		.b({pxm_s7, pym_s7, pym_s7, pxm_s7}),
		.in_side({org_s7, u1n_s7, u2n_s7, pxn_s7, pyn_s7, u1_s7, u2_s7}),
		.out_valid(m_valid), .p(m_p), .out_side(m_side)
	);

	logic                 m_u1n, m_u2n, m_pxn, m_pyn;
	logic signed [SW-1:0] ta_u, tb_u, tc_u, td_u, ta, tb, tc, td;

	assign m_pyn = m_side[2*W];
	assign m_pxn = m_side[2*W+1];
	assign m_u2n = m_side[2*W+2];
	assign m_u1n = m_side[2*W+3];

	assign ta_u = {2'b00, m_p[0*2*W +: 2*W]};
	assign tb_u = {2'b00, m_p[1*2*W +: 2*W]};
	assign tc_u = {2'b00, m_p[2*2*W +: 2*W]};
	assign td_u = {2'b00, m_p[3*2*W +: 2*W]};
	assign ta   = (m_u1n ^ m_pxn) ? -ta_u : ta_u;
	assign tb   = (m_u2n ^ m_pyn) ? -tb_u : tb_u;
	assign tc   = (m_u1n ^ m_pyn) ? -tc_u : tc_u;
	assign td   = (m_u2n ^ m_pxn) ? -td_u : td_u;

	logic                 valid_s9, org_s9;
	logic signed [SW-1:0] sum1_s9, sum2_s9;
	logic [W-1:0]         u1_s9, u2_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s9 <= m_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum1_s9 <= ta + tb;
			sum2_s9 <= tc - td;
			org_s9  <= m_side[2*W+4];
			u1_s9   <= m_side[2*W-1:W];
			u2_s9   <= m_side[W-1:0];
		end
	end

	logic         valid_s10, org_s10;
	logic [W-1:0] u1_s10, u2_s10, p1_s10, p2_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (en) begin
			valid_s10 <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			org_s10 <= org_s9;
			u1_s10  <= org_s9 ? '0 : u1_s9;
			u2_s10  <= org_s9 ? '0 : u2_s9;
			p1_s10  <= org_s9 ? '0 : shsat(sum1_s9);
			p2_s10  <= org_s9 ? '0 : shsat(sum2_s9);
		end
	end

	assign out_valid = valid_s10;
	assign out_u1    = u1_s10;
	assign out_u2    = u2_s10;
	assign out_p1    = p1_s10;
	assign out_p2    = p2_s10;
	assign out_org   = org_s10;

endmodule

@@ rtl/core/regularize_two_body_coordinates_unit.sv @@
// ----------------------------------------------------------------------------
// regularize_two_body_coordinates_unit
// Planar two-body regularization of positions and momenta, fixed point.
// ----------------------------------------------------------------------------
// Each input transfer on s_* carries position and momentum of two particles;
// each output transfer on m_* carries their regularized coordinates, momenta
// and the origin flags. One result per input, in order.
// The two particles run in two identical lanes; each lane is a fully
// pipelined chain of a squaring multiplier, a radius square root, a second
// square root, a restoring divider and a momentum multiplier bank.
// Throughput: one transfer per cycle while s_tready is high.
// Most of the pipeline depth lies in the bit-per-stage root and divider stages.
// Reset clears all valid bits; the block takes input right after reset.
// When m_tready is low the output register holds its result and one more
// result lands in a skid register; then s_tready drops and the whole
// pipeline holds until the receiver takes a transfer.
// ----------------------------------------------------------------------------
module regularize_two_body_coordinates_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// e1_pos_x, e1_pos_y, e1_mom_x, e1_mom_y, e2_pos_x, e2_pos_y, e2_mom_x, e2_mom_y
	input  logic [rtbc_pkg::NUM_LANES*rtbc_pkg::IN_FIELDS*DATA_WIDTH-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// e1_reg_re, e1_reg_im, e1_regmom_re, e1_regmom_im,
	// e2_reg_re, e2_reg_im, e2_regmom_re, e2_regmom_im, origin_flags, zero pad
	output logic [((rtbc_pkg::NUM_LANES*(rtbc_pkg::OUT_FIELDS*DATA_WIDTH+1)+7)/8)*8-1:0]
		m_tdata
);

	localparam int NL     = rtbc_pkg::NUM_LANES;
	localparam int IN_LW  = rtbc_pkg::IN_FIELDS * DATA_WIDTH;
	localparam int OUT_LW = rtbc_pkg::OUT_FIELDS * DATA_WIDTH;
	localparam int OUT_FW = NL * OUT_LW + NL;
	localparam int OUT_TW = ((OUT_FW + 7) / 8) * 8;
	localparam int PAD    = OUT_TW - OUT_FW;

	logic              en;
	logic [NL-1:0]     lane_valid, lane_org;
	logic [NL*OUT_LW-1:0] lane_data;
	logic              pipe_valid;
	logic [OUT_TW-1:0] pipe_data;
	logic              m_tvalid_q, skid_valid_q;
	logic [OUT_TW-1:0] out_data_q, skid_data_q;

	assign en       = !skid_valid_q;
	assign s_tready = en;

	genvar k;
	generate
		for (k = 0; k < NL; k++) begin : g_lane
			rtbc_lane #(.W(DATA_WIDTH), .F(FRAC_BITS)) u_lane (
				.clk(clk), .arst_n(arst_n), .en(en),
				.in_valid(s_tvalid && en),
				.in_data(s_tdata[k*IN_LW +: IN_LW]),
				.out_valid(lane_valid[k]),
				.out_u1(lane_data[k*OUT_LW + 0*DATA_WIDTH +: DATA_WIDTH]),
				.out_u2(lane_data[k*OUT_LW + 1*DATA_WIDTH +: DATA_WIDTH]),
				.out_p1(lane_data[k*OUT_LW + 2*DATA_WIDTH +: DATA_WIDTH]),
				.out_p2(lane_data[k*OUT_LW + 3*DATA_WIDTH +: DATA_WIDTH]),
				.out_org(lane_org[k])
			);
		end
	endgenerate

	// merge lanes into one result
	assign pipe_valid = &lane_valid;
	assign pipe_data  = {{PAD{1'b0}}, lane_org, lane_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q   <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (en) begin
			if (pipe_valid) begin
				if (!m_tvalid_q || m_tready) begin
					m_tvalid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end else if (m_tready) begin
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pipe_valid) begin
				if (!m_tvalid_q || m_tready) begin
					out_data_q <= pipe_data;
				end else begin
					skid_data_q <= pipe_data;
				end
			end
		end else if (m_tready) begin
			out_data_q <= skid_data_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ tb/tb_regularize_two_body_coordinates_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_regularize_two_body_coordinates_unit
// Checks the two-body regularization unit against a predictor of its own.
// Directed items cover the origin, the axes, the four quadrants and the most
// negative values; random items mix small, mid-range and full-range values.
// Both sides idle at random and the checker compares every field in order.
// ----------------------------------------------------------------------------
module tb_regularize_two_body_coordinates_unit;

	localparam int DW   = 32;
	localparam int FB   = 16;
	localparam int IN_W = rtbc_pkg::NUM_LANES * rtbc_pkg::IN_FIELDS * DW;
	localparam int OUT_W = ((rtbc_pkg::NUM_LANES * (rtbc_pkg::OUT_FIELDS * DW + 1) + 7) / 8) * 8;
	localparam int LATENCY = 113;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef logic signed [DW-1:0] word_t;
	typedef struct packed {
		logic [1:0] origin_flags;
		word_t e2_regmom_im, e2_regmom_re, e2_reg_im, e2_reg_re;
		word_t e1_regmom_im, e1_regmom_re, e1_reg_im, e1_reg_re;
	} regular_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_W-1:0] m_tdata;

	regular_t expected_q[$];
	int mismatches = 0;
	int results_seen = 0;
	int origin_hits = 0;
	int idle_cycles = 0;
	bit timed_out = 0;
	bit rx_idle_en = 1;

	regularize_two_body_coordinates_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	function automatic logic [127:0] isqrt(logic [127:0] n);
		logic [127:0] res;
		logic [127:0] c;
		res = 0;
		for (int b = 63; b >= 0; b--) begin
			c = res | (128'd1 << b);
			if (c * c <= n) res = c;
		end
		return res;
	endfunction

	function automatic word_t sat(logic signed [129:0] v);
		if (v > 130'sd2147483647) return 32'sh7fffffff;
		if (v < -130'sd2147483648) return 32'sh80000000;
		return v[DW-1:0];
	endfunction

	// trunc toward zero of v / 2^(FB-1)
	function automatic logic signed [129:0] shr_trunc(logic signed [129:0] v);
		if (v < 0) return -((-v) >>> (FB - 1));
		return v >>> (FB - 1);
	endfunction

	function automatic logic [4*DW:0] regularize_particle(word_t x, word_t y, word_t px,
			word_t py);
		logic [127:0] xm, ym, r, s;
		logic signed [129:0] v, u1, u2, p1, p2;
		word_t u1s, u2s;
		xm = x < 0 ? 128'(-66'(x)) : 128'(x);
		ym = y < 0 ? 128'(-66'(y)) : 128'(y);
		r = isqrt(xm * xm + ym * ym);
		s = isqrt((r + xm) << (FB - 1));
		if (s == 0) return {1'b1, {4 * DW{1'b0}}};
		v = 130'((ym << (FB - 1)) / s);
		if (y < 0) v = -v;
		u1 = x < 0 ? v : 130'(s);
		u2 = x < 0 ? 130'(s) : v;
		u1s = sat(u1);
		u2s = sat(u2);
		p1 = shr_trunc(130'(u1s) * 130'(px) + 130'(u2s) * 130'(py));
		p2 = shr_trunc(130'(u1s) * 130'(py) - 130'(u2s) * 130'(px));
		return {1'b0, sat(p2), sat(p1), u2s, u1s};
	endfunction

	function automatic regular_t regularize_pair(logic [IN_W-1:0] d);
		regular_t e;
		logic [4*DW:0] a, b;
		a = regularize_particle(d[0+:DW], d[DW+:DW], d[2*DW+:DW], d[3*DW+:DW]);
		b = regularize_particle(d[4*DW+:DW], d[5*DW+:DW], d[6*DW+:DW], d[7*DW+:DW]);
		{e.e1_regmom_im, e.e1_regmom_re, e.e1_reg_im, e.e1_reg_re} = a[4*DW-1:0];
		{e.e2_regmom_im, e.e2_regmom_re, e.e2_reg_im, e.e2_reg_re} = b[4*DW-1:0];
		e.origin_flags = {b[4*DW], a[4*DW]};
		return e;
	endfunction

	// s_tvalid stays high after a transfer; it drops only before an idle gap
	task automatic send_item(word_t x1, word_t y1, word_t px1, word_t py1,
			word_t x2, word_t y2, word_t px2, word_t py2);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {py2, px2, y2, x2, py1, px1, y1, x1};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_q.push_back(regularize_pair({py2, px2, y2, x2, py1, px1, y1, x1}));
	endtask

	task automatic wait_drained();
		s_tvalid <= 0;
		@(posedge clk);
		while (expected_q.size() != 0 && !timed_out) @(posedge clk);
	endtask

	function automatic word_t rand_word();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 8) - 4;
			1: return $signed($urandom) >>> $urandom_range(8, 20);
			2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_origin_and_axes();
		send_item(0, 0, 5, -7, 0, 0, 32'sh80000000, 32'sh7fffffff);
		send_item(65536, 0, 65536, 65536, 0, 65536, -65536, 65536);
		send_item(-65536, 0, 3, 4, 0, -65536, 4, 3);
		send_item(1, 0, 1, 1, -1, 0, -1, -1);
		send_item(0, 1, 0, 0, 0, -1, 0, 0);
		send_item(0, 0, 0, 0, 1, 1, 1, 1);
	endtask

	task automatic test_quadrants();
		send_item(3 << 16, 4 << 16, 1 << 16, 2 << 16, -(3 << 16), 4 << 16, 2 << 16, -(1 << 16));
		send_item(-(3 << 16), -(4 << 16), -(1 << 16), 5 << 16,
			3 << 16, -(4 << 16), 7 << 16, 7 << 16);
		send_item(12345, -678, -999, 4242, -77777, 88888, 31, -31);
	endtask

	task automatic test_extremes();
		send_item(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_item(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		send_item(32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff,
			0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_item(32'sh80000000, 1, -1, -1, 32'sh7fffffff, 0, -1, 1);
		send_item(-1, -1, -1, -1, 32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555);
	endtask

	task automatic test_random(int n);
		word_t f[8];
		for (int i = 0; i < n; i++) begin
			foreach (f[k]) f[k] = rand_word();
			if ($urandom_range(0, 15) == 0) begin
				f[0] = 0;
				f[1] = 0;
			end
			if ($urandom_range(0, 15) == 0) begin
				f[4] = 0;
				f[5] = 0;
			end
			send_item(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]);
			if (i == n / 2) begin
				wait_drained();
				rx_idle_en = 0;
			end
			if (i == 3 * n / 4) rx_idle_en = 1;
		end
	endtask

	// receiver with random stalls
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = rx_idle_en ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19)) : 0;
			if (gap != 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		regular_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = regular_t'(m_tdata[$bits(regular_t)-1:0]);
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer: %h", got);
			end else begin
				want = expected_q.pop_front();
				if (want.origin_flags != 0) origin_hits++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d\n  expected %h\n  actual   %h",
							results_seen, want, got);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("tb_regularize_two_body_coordinates_unit NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_origin_and_axes();
		test_quadrants();
		test_extremes();
		test_random(500);
		wait_drained();
		repeat (LATENCY + 20) @(posedge clk);
		$display("%0d results checked, %0d with a particle at the origin", results_seen,
			origin_hits);
		$display("directed axes, quadrants and extremes plus random full-range items");
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("tb_regularize_two_body_coordinates_unit OK");
		end else begin
			$display("tb_regularize_two_body_coordinates_unit NOT OK");
		end
		$finish;
	end

endmodule
